// ----- design/boolean_infix_to_postfix_unit_assert.svh -----
// Assertion macros shared by the infix-to-postfix converter.
`ifndef BOOLEAN_INFIX_TO_POSTFIX_UNIT_ASSERT_SVH
`define BOOLEAN_INFIX_TO_POSTFIX_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BITP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BITP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- design/bitp_pkg.sv -----
// Types, codes and the priority table of the infix-to-postfix converter.
package bitp_pkg;

	// Operator stack geometry.
	localparam int STACK_DEPTH = 16;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	// Input token kinds.
	localparam logic [2:0] KIND_OPERAND = 3'd0;
	localparam logic [2:0] KIND_OPERATOR = 3'd1;
	localparam logic [2:0] KIND_OPEN = 3'd2;
	localparam logic [2:0] KIND_CLOSE = 3'd3;
	localparam logic [2:0] KIND_END = 3'd4;

	// Emitted token kinds.
	localparam logic [1:0] TK_OPERAND = 2'd0;
	localparam logic [1:0] TK_OPERATOR = 2'd1;
	localparam logic [1:0] TK_END = 2'd2;

	// Operator codes and the stack mark of an open paren.
	localparam logic [3:0] OPR_NOT = 4'd0;
	localparam logic [3:0] OPR_OR = 4'd1;
	localparam logic [3:0] OPR_AND = 4'd2;
	localparam logic [3:0] OPR_XOR = 4'd3;
	localparam logic [3:0] OPR_EQV = 4'd4;
	localparam logic [3:0] OPR_IMP = 4'd5;
	localparam logic [3:0] OPR_NIMP = 4'd6;
	localparam logic [3:0] OPR_NOR = 4'd7;
	localparam logic [3:0] OPR_NAND = 4'd8;
	localparam logic [3:0] OPR_MAX = OPR_NAND;
	localparam logic [3:0] PAREN_MARK = 4'd15;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TOP,
		ST_FIN
	} state_t;

	// Binding priority of an operator; higher binds tighter.
	function automatic logic [2:0] prio(input logic [3:0] code);
		logic [2:0] p;
		case (code)
			OPR_NOT:  p = 3'd6;
			OPR_OR:   p = 3'd3;
			OPR_AND:  p = 3'd5;
			OPR_XOR:  p = 3'd4;
			OPR_EQV:  p = 3'd1;
			OPR_IMP:  p = 3'd2;
			OPR_NIMP: p = 3'd2;
			OPR_NOR:  p = 3'd3;
			OPR_NAND: p = 3'd5;
			default:  p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

// ----- design/boolean_infix_to_postfix_unit.sv -----
// Top level of the shunting-yard converter from boolean infix tokens to postfix tokens.

// Takes one token per input beat and emits postfix tokens on the result channel, with last
// set on the final result beat that a token causes. An operand token comes out in the cycle
// after it is accepted. An operator, close paren or end token is accepted, then examines
// the stack entries one by one, each pop waiting on the registered read of the operator
// stack memory, then closes by flushing its pending operator and any error or end-marker
// beat; a stalled result channel holds it up, and no new token is taken until it is done.
// The stack lives in a 16-entry synchronous memory that needs no clearing pass after
// reset. A push onto a full stack is dropped and reported by a result beat with stack_error
// set; open parens still stacked at the end are discarded silently.
`include "boolean_infix_to_postfix_unit_assert.svh"

module boolean_infix_to_postfix_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [2:0] op,
	input  logic [7:0] operand_symbol,
	input  logic [3:0] operator_code,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] token_kind,
	output logic [7:0] token_value,
	output logic       stack_error,
	output logic       last
);
	import bitp_pkg::*;

	state_t              state_q, state_d;
	logic [2:0]          kind_q, kind_d;
	logic [3:0]          code_q, code_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                pend_valid_q, pend_valid_d;
	logic [3:0]          pend_value_q, pend_value_d;

	logic                res_valid_q;
	logic [1:0]          token_kind_q;
	logic [7:0]          token_value_q;
	logic                stack_error_q;
	logic                last_q;

	logic [3:0]          stack_mem [STACK_DEPTH];
	logic [3:0]          rd_data_q;
	logic                rd_en, wr_en;
	logic [ADDR_W-1:0]   rd_addr, wr_addr;

	logic                emit;
	logic [1:0]          e_kind;
	logic [7:0]          e_value;
	logic                e_err, e_last;

	logic                can_emit, accept;
	logic                stack_full, is_push_kind, has_tail;
	logic                top_paren, take, keep;

	// The result register can take a new beat when empty or being drained.
	assign can_emit = !res_valid_q || !result_stall;
	assign item_stall = !((state_q == ST_IDLE) && can_emit);
	assign accept = item_valid && !item_stall;

	assign stack_full = count_q >= CNT_W'(STACK_DEPTH);
	assign is_push_kind = (kind_q == KIND_OPERATOR) || (kind_q == KIND_OPEN);
	assign has_tail = (kind_q == KIND_END) || (is_push_kind && stack_full);

	// Decide whether the entry just read from the top of the stack is popped.
	assign top_paren = rd_data_q == PAREN_MARK;
	always_comb begin
		case (kind_q)
			KIND_OPERATOR: begin
				if (rd_data_q == OPR_NOT) begin
					take = !top_paren && (prio(rd_data_q) > prio(code_q));
				end else begin
					take = !top_paren && (prio(rd_data_q) >= prio(code_q));
				end
			end
			KIND_CLOSE: take = !top_paren;
			KIND_END:   take = 1'b1;
			default:    take = 1'b0;
		endcase
	end
	assign keep = take && !top_paren;

	// Sequencer: next state, stack accesses and result beats.
	always_comb begin
		logic start_pop;
		start_pop = 1'b0;
		state_d = state_q;
		kind_d = kind_q;
		code_d = code_q;
		count_d = count_q;
		pend_valid_d = pend_valid_q;
		pend_value_d = pend_value_q;
		rd_en = 1'b0;
		rd_addr = ADDR_W'(count_q - CNT_W'(1));
		wr_en = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		emit = 1'b0;
		e_kind = TK_OPERATOR;
		e_value = 8'(pend_value_q);
		e_err = 1'b0;
		e_last = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op) inside
						KIND_OPERAND: begin
							emit = 1'b1;
							e_kind = TK_OPERAND;
							e_value = operand_symbol;
							e_last = 1'b1;
						end
						KIND_OPERATOR: begin
							if (operator_code <= OPR_MAX) begin
								start_pop = 1'b1;
							end
						end
						KIND_OPEN: begin
							kind_d = op;
							code_d = PAREN_MARK;
							state_d = ST_FIN;
						end
						KIND_CLOSE, KIND_END: begin
							start_pop = 1'b1;
						end
						default: begin
						end
					endcase
					if (start_pop) begin
						kind_d = op;
						code_d = operator_code;
						if (count_q != '0) begin
							rd_en = 1'b1;
							state_d = ST_TOP;
						end else begin
							state_d = ST_FIN;
						end
					end
				end
			end

			// The top entry is in rd_data_q; a popped operator waits in the pending
			// register until it is known whether another beat follows it.
			ST_TOP: begin
				if (take) begin
					if (!(keep && pend_valid_q && !can_emit)) begin
						if (keep && pend_valid_q) begin
							emit = 1'b1;
						end
						if (keep) begin
							pend_valid_d = 1'b1;
							pend_value_d = rd_data_q;
						end
						count_d = count_q - CNT_W'(1);
						if (count_q > CNT_W'(1)) begin
							rd_en = 1'b1;
							rd_addr = ADDR_W'(count_q - CNT_W'(2));
						end else begin
							state_d = ST_FIN;
						end
					end
				end else begin
					// A close paren removes the open paren it stops at.
					if (kind_q == KIND_CLOSE) begin
						count_d = count_q - CNT_W'(1);
					end
					state_d = ST_FIN;
				end
			end

			// Flush the pending operator, then either the error or end beat or the push.
			ST_FIN: begin
				if (pend_valid_q) begin
					if (can_emit) begin
						emit = 1'b1;
						e_last = !has_tail;
						pend_valid_d = 1'b0;
						if (!has_tail) begin
							if (is_push_kind) begin
								wr_en = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
							state_d = ST_IDLE;
						end
					end
				end else if (has_tail) begin
					if (can_emit) begin
						emit = 1'b1;
						e_last = 1'b1;
						e_value = '0;
						if (kind_q == KIND_END) begin
							e_kind = TK_END;
						end else begin
							e_kind = TK_OPERAND;
							e_err = 1'b1;
						end
						state_d = ST_IDLE;
					end
				end else begin
					if (is_push_kind) begin
						wr_en = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
					state_d = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// Operator stack memory with a registered read port; reads and writes never
	// target the same cycle, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= code_q;
		end
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_OPERAND;
			count_q <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			count_q <= count_d;
			pend_valid_q <= pend_valid_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		code_q <= code_d;
		pend_value_q <= pend_value_d;
		if (emit) begin
			token_kind_q <= e_kind;
			token_value_q <= e_value;
			stack_error_q <= e_err;
			last_q <= e_last;
		end
	end

	assign result_valid = res_valid_q;
	assign token_kind = token_kind_q;
	assign token_value = token_value_q;
	assign stack_error = stack_error_q;
	assign last = last_q;

	`BITP_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(STACK_DEPTH), "stack count over depth")
	`BITP_ASSERT_NOW(a_top_nonempty, state_q == ST_TOP, count_q != '0, "stack read with empty stack")
	`BITP_ASSERT_NOW(a_idle_no_pend, state_q == ST_IDLE, !pend_valid_q, "pending pop left in idle")
	`BITP_ASSERT_NOW(a_err_is_last, res_valid_q && stack_error_q, last_q, "error beat not last")
	`BITP_ASSERT_NEXT(a_operand_out, accept && (op == KIND_OPERAND), res_valid_q && last_q && (token_kind_q == TK_OPERAND), "operand beat not emitted")

endmodule

// ----- tb/sv/boolean_infix_to_postfix_unit_tb.sv -----
// Testbench for the boolean infix-to-postfix converter, checked beat by beat against a scoreboard.
`timescale 1ns / 1ps

module boolean_infix_to_postfix_unit_tb;
	import bitp_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 60;
	localparam int ITEMS_PER_PHASE = 28;

	// Binding strength of each operator code, tighter binding ranks higher.
	localparam logic [2:0] OP_RANK [0:8] = '{3'd6, 3'd3, 3'd5, 3'd4, 3'd1, 3'd2, 3'd2, 3'd3, 3'd5};

	// One postfix beat as it leaves the block.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       err;
		logic       last;
	} postfix_beat_t;

	// Tracks the operator stack and holds the postfix beats still owed by the block.
	class postfix_scoreboard;
		logic [3:0] opstack [STACK_DEPTH];
		int depth;
		postfix_beat_t due[$];
		postfix_beat_t batch[$];
		int errors;
		int tokens;
		int ignored;
		int useful;
		int beats_checked;
		int overflows;
		int formulas;

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch %0d at %0t: %s", errors, $realtime, msg);
		endfunction

		function void emit(logic [1:0] kind, logic [7:0] value, logic err);
			postfix_beat_t b;
			b.kind = kind;
			b.value = value;
			b.err = err;
			b.last = 1'b0;
			batch.push_back(b);
		endfunction

		// A push onto a full stack is dropped and flagged by an error beat.
		function void push_entry(logic [3:0] entry);
			if (depth >= STACK_DEPTH) begin
				emit(TK_OPERAND, 8'd0, 1'b1);
				overflows++;
			end else begin
				opstack[depth] = entry;
				depth++;
			end
		endfunction

		// Works out the postfix beats that one accepted token causes.
		function void note_token(logic [2:0] kind, logic [7:0] sym, logic [3:0] code);
			logic [3:0] top;
			bit pops;
			batch.delete();
			tokens++;
			case (kind)
				KIND_OPERAND: begin
					emit(TK_OPERAND, sym, 1'b0);
				end
				KIND_OPERATOR: begin
					if (code <= OPR_MAX) begin
						// Pop what binds at least as tightly; a stacked not needs strictly tighter.
						while (depth > 0) begin
							top = opstack[depth - 1];
							if (top == PAREN_MARK)
								break;
							if (top == OPR_NOT)
								pops = OP_RANK[top] > OP_RANK[code];
							else
								pops = OP_RANK[top] >= OP_RANK[code];
							if (!pops)
								break;
							emit(TK_OPERATOR, {4'd0, top}, 1'b0);
							depth--;
						end
						push_entry(code);
					end
				end
				KIND_OPEN: begin
					push_entry(PAREN_MARK);
				end
				KIND_CLOSE: begin
					// Unwind to the nearest open paren, or empty the stack if there is none.
					while (depth > 0) begin
						depth--;
						top = opstack[depth];
						if (top == PAREN_MARK)
							break;
						emit(TK_OPERATOR, {4'd0, top}, 1'b0);
					end
				end
				KIND_END: begin
					// Flush operators, drop leftover open parens, then mark the end.
					while (depth > 0) begin
						depth--;
						top = opstack[depth];
						if (top != PAREN_MARK)
							emit(TK_OPERATOR, {4'd0, top}, 1'b0);
					end
					emit(TK_END, 8'd0, 1'b0);
					formulas++;
				end
				default: begin
				end
			endcase
			if (kind > KIND_END || (kind == KIND_OPERATOR && code > OPR_MAX))
				ignored++;
			else
				useful++;
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				due.push_back(batch[i]);
		endfunction

		// Compares one accepted result beat with the oldest beat owed.
		function void check_beat(logic [1:0] kind, logic [7:0] value, logic err, logic last);
			postfix_beat_t want;
			beats_checked++;
			if (due.size() == 0) begin
				report($sformatf("unexpected beat kind %0d value %0d err %b last %b",
					kind, value, err, last));
				return;
			end
			want = due.pop_front();
			if (kind !== want.kind || value !== want.value || err !== want.err ||
					last !== want.last)
				report($sformatf({"expected kind %0d value %0d err %b last %b, ",
					"got kind %0d value %0d err %b last %b"},
					want.kind, want.value, want.err, want.last, kind, value, err, last));
		endfunction

		// Anything still owed once the block has gone quiet is a failure.
		function void drain_check();
			if (due.size() > 0)
				report($sformatf("%0d expected beats never arrived", due.size()));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [2:0] op = KIND_OPERAND;
	logic [7:0] operand_symbol = 8'd0;
	logic [3:0] operator_code = OPR_NOT;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] token_kind;
	logic [7:0] token_value;
	logic       stack_error;
	logic       last;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	postfix_scoreboard board;

	boolean_infix_to_postfix_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.operand_symbol(operand_symbol),
		.operator_code(operator_code),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.token_kind(token_kind),
		.token_value(token_value),
		.stack_error(stack_error),
		.last(last)
	);

	always #5 clk = ~clk;

	// Random back-pressure on the result channel.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Every accepted result beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_beat(token_kind, token_value, stack_error, last);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offers one token, idling first at random, and holds it until accepted.
	task automatic send_token(input logic [2:0] kind, input logic [7:0] sym,
			input logic [3:0] code);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			op <= 3'($urandom);
			operand_symbol <= 8'($urandom);
			operator_code <= 4'($urandom);
			@(negedge clk);
		end
		item_valid <= 1'b1;
		op <= kind;
		operand_symbol <= sym;
		operator_code <= code;
		do
			@(posedge clk);
		while (item_stall);
		board.note_token(kind, sym, code);
	endtask

	// Tokens the block should ignore, plus stray close parens.
	task automatic send_noise();
		case ($urandom_range(2))
			0: send_token(3'($urandom_range(7, 5)), 8'($urandom), 4'($urandom));
			1: send_token(KIND_OPERATOR, 8'($urandom), 4'($urandom_range(15, 9)));
			default: send_token(KIND_CLOSE, 8'($urandom), 4'($urandom));
		endcase
	endtask

	// Sends one random formula; most are well formed, a few are cut short or unbalanced.
	task automatic send_formula(input int nest_pct);
		int open_count;
		int budget;
		int roll;
		bit need_operand;
		open_count = 0;
		budget = $urandom_range(28, 3);
		need_operand = 1'b1;
		while (budget > 0) begin
			budget--;
			roll = $urandom_range(99);
			if (roll < 5) begin
				send_noise();
			end else if (need_operand) begin
				if (roll < 5 + nest_pct) begin
					send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
					open_count++;
				end else if (roll < 20 + nest_pct) begin
					send_token(KIND_OPERATOR, 8'($urandom), OPR_NOT);
				end else begin
					send_token(KIND_OPERAND, 8'($urandom), 4'($urandom));
					need_operand = 1'b0;
				end
			end else if (open_count > 0 && roll < 40) begin
				send_token(KIND_CLOSE, 8'($urandom), 4'($urandom));
				open_count--;
			end else begin
				send_token(KIND_OPERATOR, 8'($urandom), 4'($urandom_range(8, 1)));
				need_operand = 1'b1;
			end
		end
		// Most formulas get their last operand and closing parens before the end token.
		if ($urandom_range(99) < 85) begin
			if (need_operand)
				send_token(KIND_OPERAND, 8'($urandom), 4'($urandom));
			while (open_count > 0) begin
				send_token(KIND_CLOSE, 8'($urandom), 4'($urandom));
				open_count--;
			end
		end
		send_token(KIND_END, 8'($urandom), 4'($urandom));
	endtask

	// Random formulas until the phase has sent its share of meaningful tokens.
	task automatic run_phase(input int idle_pct, input int stall_pct);
		int start_count;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start_count = board.useful;
		while (board.useful - start_count < ITEMS_PER_PHASE)
			send_formula(($urandom_range(9) == 0) ? 75 : 20);
	endtask

	initial begin
		board = new;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Operand extremes, not popped by nand, ignored tokens and the paren cases.
		send_token(KIND_OPERAND, 8'h00, 4'($urandom));
		send_token(KIND_OPERAND, 8'hFF, 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_NOT);
		send_token(KIND_OPERATOR, 8'($urandom), OPR_NAND);
		send_token(KIND_OPERATOR, 8'($urandom), 4'd9);
		send_token(3'd7, 8'($urandom), 4'($urandom));
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_EQV);
		send_token(KIND_CLOSE, 8'($urandom), 4'($urandom));
		send_token(KIND_CLOSE, 8'($urandom), 4'($urandom));
		send_token(KIND_CLOSE, 8'($urandom), 4'($urandom));

		// Fill the stack to the brim without pops, overflow it, then flush past open parens.
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_EQV);
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_IMP);
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_OR);
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_XOR);
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_AND);
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_NOT);
		send_token(KIND_OPERATOR, 8'($urandom), OPR_NOT);
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_NIMP);
		send_token(KIND_OPEN, 8'($urandom), 4'($urandom));
		send_token(KIND_OPERATOR, 8'($urandom), OPR_NOR);
		send_token(KIND_END, 8'($urandom), 4'($urandom));

		// Random formulas under each flow-control pattern.
		run_phase(0, 0);
		run_phase(73, 0);
		run_phase(0, 73);
		run_phase(27, 27);

		@(negedge clk);
		item_valid <= 1'b0;
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		board.drain_check();

		$display("run covered %0d tokens (%0d ignored), %0d formulas, %0d stack overflows",
			board.tokens, board.ignored, board.formulas, board.overflows);
		$display("%0d postfix beats checked, %0d mismatches", board.beats_checked, board.errors);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/bitp_pkg.sv
design/boolean_infix_to_postfix_unit.sv
tb/sv/boolean_infix_to_postfix_unit_tb.sv
